/* design/ssm_pkg.sv */
`default_nettype none

package ssm_pkg;

    localparam int KEY_W    = 12;
    localparam int CODE_W   = 32;
    localparam int CNT_W    = 13;
    localparam int MODE_W   = 2;
    localparam int DEF_KEYS = 4096;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_LOOKUP = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SLOT,
        ST_CHECK,
        ST_MOVE
    } t_state;

endpackage

`default_nettype wire

/* design/ssm_ram.sv */
`default_nettype none

module ssm_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/sparse_set_key_value_map.sv */
`default_nettype none

// channel  dir  handshake               payload
// s        in   i_s_tvalid/o_s_tready   tuser: mode; tdata: key, code_in
// m        out  o_m_tvalid/i_m_tready   tuser: found; tdata: code_out, member_count
//
// Insert, lookup and remove read the slot of the key (ST_IDLE), then the key
// and code at that slot (ST_SLOT), and decide in ST_CHECK; clear goes straight
// to ST_CHECK. A remove of a member that leaves members behind adds ST_MOVE,
// which moves the last entry into the freed slot.
// After reset the slot-of-key memory is swept to zero, all KEYS entries (4096 by
// default), with o_s_tready low. A result waits in the output register; a new
// request is taken meanwhile, and its ST_CHECK and ST_MOVE stall while m is blocked.
module sparse_set_key_value_map
    import ssm_pkg::*;
#(
    parameter int KEYS = DEF_KEYS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [47:0]       i_s_tdata,   // [11:0] key, [43:12] code_in
    input  wire logic [MODE_W-1:0] i_s_tuser,   // [1:0] mode
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [47:0]       o_m_tdata,   // [31:0] code_out, [44:32] member_count
    output logic                   o_m_tuser    // [0] found
);

    localparam int AW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CW = $clog2(KEYS + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_init_addr;
    t_mode             r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [CODE_W-1:0] r_code;
    logic              r_out_valid;
    logic              r_found, n_found;
    logic [CODE_W-1:0] r_code_out, n_code_out;
    logic [CNT_W-1:0]  r_out_count;
    logic              load;

    logic              sok_we, sok_re;
    logic [AW-1:0]     sok_waddr, sok_raddr, sok_wdata, sok_q;
    logic              kas_we, kas_re;
    logic [AW-1:0]     kas_waddr, kas_raddr;
    logic [KEY_W-1:0]  kas_wdata, kas_q;
    logic              cas_we, cas_re;
    logic [AW-1:0]     cas_waddr, cas_raddr;
    logic [CODE_W-1:0] cas_wdata, cas_q;

    logic              accept, out_free, key_ok, hit, room, moved_ok;
    logic [CW-1:0]     cnt_dec;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign key_ok   = 32'(r_key) < 32'(KEYS);
    assign hit      = key_ok && (CW'(sok_q) < r_count) && (kas_q == r_key);
    assign room     = r_count < CW'(KEYS);
    assign cnt_dec  = r_count - CW'(1);
    assign moved_ok = 32'(kas_q) < 32'(KEYS);

    ssm_ram #(.DEPTH(KEYS), .WIDTH(AW)) u_slot_of_key (
        .i_clk   (i_clk),
        .i_we    (sok_we),
        .i_waddr (sok_waddr),
        .i_wdata (sok_wdata),
        .i_re    (sok_re),
        .i_raddr (sok_raddr),
        .o_rdata (sok_q)
    );

    ssm_ram #(.DEPTH(KEYS), .WIDTH(KEY_W)) u_key_at_slot (
        .i_clk   (i_clk),
        .i_we    (kas_we),
        .i_waddr (kas_waddr),
        .i_wdata (kas_wdata),
        .i_re    (kas_re),
        .i_raddr (kas_raddr),
        .o_rdata (kas_q)
    );

    ssm_ram #(.DEPTH(KEYS), .WIDTH(CODE_W)) u_code_at_slot (
        .i_clk   (i_clk),
        .i_we    (cas_we),
        .i_waddr (cas_waddr),
        .i_wdata (cas_wdata),
        .i_re    (cas_re),
        .i_raddr (cas_raddr),
        .o_rdata (cas_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_init_addr == AW'(KEYS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = (t_mode'(i_s_tuser) == MODE_CLEAR) ? ST_CHECK : ST_SLOT;
                end
            end
            ST_SLOT: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (out_free) begin
                    if (r_mode == MODE_REMOVE && hit && cnt_dec != '0) begin
                        n_state = ST_MOVE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MOVE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
        sok_we     = 1'b0;
        sok_waddr  = AW'(r_key);
        sok_wdata  = '0;
        sok_re     = 1'b0;
        sok_raddr  = AW'(i_s_tdata[KEY_W-1:0]);
        kas_we     = 1'b0;
        kas_waddr  = sok_q;
        kas_wdata  = r_key;
        kas_re     = 1'b0;
        kas_raddr  = sok_q;
        cas_we     = 1'b0;
        cas_waddr  = sok_q;
        cas_wdata  = r_code;
        cas_re     = 1'b0;
        cas_raddr  = sok_q;
        n_count    = r_count;
        load       = 1'b0;
        n_found    = 1'b0;
        n_code_out = '0;
        unique case (r_state)
            ST_INIT: begin
                sok_we    = 1'b1;
                sok_waddr = r_init_addr;
            end
            ST_IDLE: begin
                sok_re = accept;
            end
            ST_SLOT: begin
                kas_re = 1'b1;
                cas_re = 1'b1;
            end
            ST_CHECK: begin
                if (out_free) begin
                    load = 1'b1;
                    unique case (r_mode)
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        MODE_INSERT: begin
                            n_found = hit;
                            if (hit) begin
                                cas_we = 1'b1;
                            end else if (key_ok && room) begin
                                sok_we    = 1'b1;
                                sok_wdata = AW'(r_count);
                                kas_we    = 1'b1;
                                kas_waddr = AW'(r_count);
                                cas_we    = 1'b1;
                                cas_waddr = AW'(r_count);
                                n_count   = r_count + CW'(1);
                            end
                        end
                        MODE_REMOVE: begin
                            n_found = hit;
                            if (hit) begin
                                n_count = cnt_dec;
                                if (cnt_dec != '0) begin
                                    load      = 1'b0;
                                    kas_re    = 1'b1;
                                    kas_raddr = AW'(cnt_dec);
                                    cas_re    = 1'b1;
                                    cas_raddr = AW'(cnt_dec);
                                end
                            end
                        end
                        MODE_LOOKUP: begin
                            n_found    = hit;
                            n_code_out = hit ? cas_q : '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOVE: begin
                if (out_free) begin
                    load      = 1'b1;
                    n_found   = 1'b1;
                    sok_we    = moved_ok;
                    sok_waddr = AW'(kas_q);
                    sok_wdata = sok_q;
                    kas_we    = 1'b1;
                    kas_wdata = kas_q;
                    cas_we    = 1'b1;
                    cas_wdata = cas_q;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init_addr <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_INIT) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_s_tuser);
            r_key  <= i_s_tdata[KEY_W-1:0];
            r_code <= i_s_tdata[KEY_W +: CODE_W];
        end
        if (load) begin
            r_found     <= n_found;
            r_code_out  <= n_code_out;
            r_out_count <= CNT_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_found;
    assign o_m_tdata  = {3'b000, r_out_count, r_code_out};

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(KEYS))
        else $error("member count above capacity");

    a_no_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |-> !o_s_tready)
        else $error("request taken during clearing sweep");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> out_free)
        else $error("result overwrites a pending one");

    a_move_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE) |-> (r_mode == MODE_REMOVE && $past(r_state) != ST_IDLE))
        else $error("move step outside a remove");

endmodule

`default_nettype wire

/* sim/sparse_set_key_value_map_tb.sv */
`timescale 1ns / 100ps

module sparse_set_key_value_map_tb;
    import ssm_pkg::*;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  members;
    } t_map_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [47:0]       i_s_tdata;   // [11:0] key, [43:12] code_in
    logic [MODE_W-1:0] i_s_tuser;   // [1:0] mode
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [47:0]       o_m_tdata;   // [31:0] code_out, [44:32] member_count
    logic              o_m_tuser;   // [0] found

    // shadow copy of the map
    bit [KEY_W-1:0]  slot_of_key [DEF_KEYS];
    bit [KEY_W-1:0]  key_at_slot [DEF_KEYS];
    bit [CODE_W-1:0] code_at_slot [DEF_KEYS];
    bit [CNT_W-1:0]  live_count;

    t_map_result pending_results[$];
    t_map_result got_result;
    t_map_result want_result;
    int          mismatch_count = 0;
    int          burst_left;
    bit          gaps_on;
    int          rx_style = 0;
    int          rx_left = 0;
    int unsigned rx_tick = 0;

    sparse_set_key_value_map dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_map_result map_apply(t_mode mode, logic [KEY_W-1:0] key,
                                              logic [CODE_W-1:0] code);
        t_map_result    r;
        logic [KEY_W-1:0] slot;
        logic [KEY_W-1:0] moved;
        logic           hit;
        r = '0;
        slot = slot_of_key[key];
        hit = (mode != MODE_CLEAR) && (slot < live_count) && (key_at_slot[slot] == key);
        case (mode)
            MODE_CLEAR: begin
                live_count = '0;
            end
            MODE_INSERT: begin
                if (hit) begin
                    code_at_slot[slot] = code;
                end else if (live_count < DEF_KEYS) begin
                    key_at_slot[live_count[KEY_W-1:0]] = key;
                    code_at_slot[live_count[KEY_W-1:0]] = code;
                    slot_of_key[key] = live_count[KEY_W-1:0];
                    live_count++;
                end
            end
            MODE_REMOVE: begin
                if (hit) begin
                    live_count--;
                    if (live_count != 0) begin
                        moved = key_at_slot[live_count[KEY_W-1:0]];
                        slot_of_key[moved] = slot;
                        key_at_slot[slot] = moved;
                        code_at_slot[slot] = code_at_slot[live_count[KEY_W-1:0]];
                    end
                end
            end
            default: begin
                if (hit) r.code = code_at_slot[slot];
            end
        endcase
        r.found = hit;
        r.members = live_count;
        return r;
    endfunction

    task automatic send_request(input t_mode mode, input logic [KEY_W-1:0] key,
                                input logic [CODE_W-1:0] code);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {4'b0, code, key};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(map_apply(mode, key, code));
        if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_on) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic report_field(input string field, input logic [CODE_W-1:0] want,
                                input logic [CODE_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
        end
    endtask

    // receiver: stall style is redrawn whenever its countdown runs out
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left  <= $urandom_range(50, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= (rx_tick % 7) < 3;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_result.found   = o_m_tuser;
            got_result.code    = o_m_tdata[31:0];
            got_result.members = o_m_tdata[44:32];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result %h", $realtime, got_result);
            end else begin
                want_result = pending_results.pop_front();
                report_field("found", want_result.found, got_result.found);
                report_field("code_out", want_result.code, got_result.code);
                report_field("member_count", want_result.members, got_result.members);
            end
        end
    end

    task automatic test_empty_map;
        gaps_on = 1'b0;
        send_request(MODE_LOOKUP, 12'd0, 32'hFFFF_FFFF);
        send_request(MODE_LOOKUP, 12'hFFF, 32'h0);
        send_request(MODE_REMOVE, 12'd0, 32'h1234_5678);
        send_request(MODE_CLEAR, 12'hFFF, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_directed_ops;
        gaps_on = 1'b1;
        send_request(MODE_INSERT, 12'd0, 32'h7FFF_FFFF);
        send_request(MODE_INSERT, 12'hFFF, 32'h8000_0000);
        send_request(MODE_INSERT, 12'd5, 32'hFFFF_FFFF);
        send_request(MODE_LOOKUP, 12'd0, 32'h0);
        send_request(MODE_LOOKUP, 12'hFFF, 32'h0);
        send_request(MODE_INSERT, 12'd0, 32'h0);
        send_request(MODE_LOOKUP, 12'd0, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 12'd5, 32'hA5A5_5A5A);
        // remove of the first slot pulls the last entry down
        send_request(MODE_REMOVE, 12'd0, 32'h0);
        send_request(MODE_LOOKUP, 12'd5, 32'h0);
        send_request(MODE_LOOKUP, 12'hFFF, 32'h0);
        send_request(MODE_LOOKUP, 12'd0, 32'h0);
        send_request(MODE_REMOVE, 12'd0, 32'h0);
        // remove of the entry in the first slot pulls the last entry down again
        send_request(MODE_REMOVE, 12'd5, 32'h0);
        send_request(MODE_LOOKUP, 12'hFFF, 32'h0);
        send_request(MODE_REMOVE, 12'hFFF, 32'h0);
        send_request(MODE_INSERT, 12'd77, 32'h0000_0001);
        send_request(MODE_INSERT, 12'd78, 32'hFFFF_FFFE);
        send_request(MODE_CLEAR, 12'd0, 32'h0);
        // stale entries must not look like members after a clear
        send_request(MODE_LOOKUP, 12'd77, 32'h0);
        send_request(MODE_REMOVE, 12'd78, 32'h0);
        send_request(MODE_INSERT, 12'd78, 32'h5555_AAAA);
        send_request(MODE_LOOKUP, 12'd78, 32'h0);
        send_request(MODE_LOOKUP, 12'd77, 32'h0);
        send_request(MODE_CLEAR, 12'd0, 32'h0);
        drain();
    endtask

    task automatic test_bulk_fill;
        logic [KEY_W-1:0] key;
        gaps_on = 1'b0;
        for (int i = 0; i < 160; i++) begin
            key = KEY_W'(i * 1237);
            send_request(MODE_INSERT, key, $urandom);
        end
        gaps_on = 1'b1;
        send_request(MODE_LOOKUP, 12'd0, 32'h0);
        send_request(MODE_LOOKUP, 12'hFFF, 32'h0);
        send_request(MODE_INSERT, 12'd300, 32'hDEAD_BEEF);
        send_request(MODE_LOOKUP, 12'd300, 32'h0);
        for (int i = 0; i < 6; i++) begin
            key = KEY_W'($urandom_range(0, DEF_KEYS - 1));
            send_request(MODE_REMOVE, key, 32'h0);
            send_request(MODE_LOOKUP, key, 32'h0);
            send_request(MODE_INSERT, key, $urandom);
            send_request(MODE_LOOKUP, key, 32'h0);
        end
        send_request(MODE_CLEAR, 12'd0, 32'h0);
        send_request(MODE_LOOKUP, 12'd300, 32'h0);
        drain();
    endtask

    task automatic test_random_ops;
        logic [KEY_W-1:0] key_pool [48];
        logic [KEY_W-1:0] key;
        logic [CODE_W-1:0] code;
        int unsigned      pick;
        t_mode            mode;
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, DEF_KEYS - 1));
        key_pool[0] = 12'd0;
        key_pool[1] = 12'hFFF;
        for (int n = 0; n < 330; n++) begin
            if (n % 100 == 0) gaps_on = (n % 200 == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)      mode = MODE_INSERT;
            else if (pick < 60) mode = MODE_REMOVE;
            else if (pick < 96) mode = MODE_LOOKUP;
            else                mode = MODE_CLEAR;
            if ($urandom_range(0, 4) != 0) key = key_pool[$urandom_range(0, 47)];
            else                           key = KEY_W'($urandom_range(0, DEF_KEYS - 1));
            code = $urandom;
            send_request(mode, key, code);
        end
        drain();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= MODE_INSERT;
        burst_left = 0;
        gaps_on = 1'b0;
        live_count = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_map();
        test_directed_ops();
        test_bulk_fill();
        test_random_ops();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
